>>> rtl/nebs_pkg.sv
// Shared constants and types for the nearest-entry binary search unit.
package nebs_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int VALUE_WIDTH = 32;
   localparam int INDEX_WIDTH = $clog2(TABLE_DEPTH);
   localparam int COUNT_WIDTH = 11;
   localparam int DIFF_WIDTH  = VALUE_WIDTH + 1;

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef struct packed {
      logic                   wr_en;
      logic [INDEX_WIDTH-1:0] wr_addr;
      logic [VALUE_WIDTH-1:0] wr_data;
      logic                   rd_en;
      logic [INDEX_WIDTH-1:0] rd_addr;
   } mem_req_type;

endpackage

>>> rtl/nebs_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module nebs_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/nebs_ctrl.sv
// Search sequencer: table writes, orientation check, bisection and nearest pick.
module nebs_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [nebs_pkg::COUNT_WIDTH-1:0] entry_count,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  nebs_pkg::opcode_type            req_opcode,
   input  logic [nebs_pkg::INDEX_WIDTH-1:0] req_index,
   input  logic [nebs_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [nebs_pkg::INDEX_WIDTH-1:0] rsp_index,
   output nebs_pkg::mem_req_type           mem_req,
   input  logic [nebs_pkg::VALUE_WIDTH-1:0] rd_data
);

   import nebs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_FIRST,
      S_RD_LAST,
      S_ORIENT,
      S_PROBE,
      S_BISECT,
      S_DIFF,
      S_PICK,
      S_OUT
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [INDEX_WIDTH-1:0] last_ff, last_in;
   logic [VALUE_WIDTH-1:0] first_ff, first_in;
   logic [INDEX_WIDTH-1:0] lo_ff, lo_in;
   logic [INDEX_WIDTH-1:0] hi_ff, hi_in;
   logic [INDEX_WIDTH-1:0] mid_ff, mid_in;
   logic [VALUE_WIDTH-1:0] vlo_ff, vlo_in;
   logic [VALUE_WIDTH-1:0] vhi_ff, vhi_in;
   logic [DIFF_WIDTH-1:0]  dlo_ff, dlo_in;
   logic [DIFF_WIDTH-1:0]  dhi_ff, dhi_in;
   logic [INDEX_WIDTH-1:0] res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_WIDTH-1:0] rsp_index_ff, rsp_index_in;

   logic [COUNT_WIDTH-1:0] count_sat;
   logic [INDEX_WIDTH-1:0] span;
   logic [INDEX_WIDTH:0]   mid_sum;
   logic                   span_open;
   logic                   accept;

   always_comb begin
      count_sat = (entry_count > COUNT_WIDTH'(TABLE_DEPTH)) ?
                  COUNT_WIDTH'(TABLE_DEPTH) : entry_count;
      span      = (hi_ff > lo_ff) ? (hi_ff - lo_ff) : (lo_ff - hi_ff);
      span_open = (span > INDEX_WIDTH'(1));
      mid_sum   = {1'b0, hi_ff} + {1'b0, lo_ff};
      accept    = req_valid && (state_ff == S_IDLE);
   end

   always_comb begin
      mem_req.wr_en   = accept && (req_opcode == OP_WRITE);
      mem_req.wr_addr = req_index;
      mem_req.wr_data = req_value;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = '0;
      case (state_ff)
         S_RD_FIRST: begin
            mem_req.rd_en = 1'b1;
         end
         S_RD_LAST: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = last_ff;
         end
         S_PROBE: begin
            mem_req.rd_en   = span_open;
            mem_req.rd_addr = mid_sum[INDEX_WIDTH:1];
         end
         default: begin
            mem_req.rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      first_in     = first_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      vlo_in       = vlo_ff;
      vhi_in       = vhi_ff;
      dlo_in       = dlo_ff;
      dhi_in       = dhi_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_opcode == OP_QUERY)) begin
               key_in  = req_value;
               last_in = INDEX_WIDTH'(count_sat - COUNT_WIDTH'(1));
               if (count_sat <= COUNT_WIDTH'(1)) begin
                  res_in   = '0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_RD_FIRST;
               end
            end
         end
         S_RD_FIRST: begin
            state_in = S_RD_LAST;
         end
         S_RD_LAST: begin
            first_in = rd_data;
            state_in = S_ORIENT;
         end
         S_ORIENT: begin
            if ($signed(first_ff) > $signed(rd_data)) begin
               lo_in  = last_ff;
               hi_in  = '0;
               vlo_in = rd_data;
               vhi_in = first_ff;
            end else begin
               lo_in  = '0;
               hi_in  = last_ff;
               vlo_in = first_ff;
               vhi_in = rd_data;
            end
            state_in = S_PROBE;
         end
         S_PROBE: begin
            mid_in   = mid_sum[INDEX_WIDTH:1];
            state_in = span_open ? S_BISECT : S_DIFF;
         end
         S_BISECT: begin
            if ($signed(rd_data) > $signed(key_ff)) begin
               hi_in  = mid_ff;
               vhi_in = rd_data;
            end else begin
               lo_in  = mid_ff;
               vlo_in = rd_data;
            end
            state_in = S_PROBE;
         end
         S_DIFF: begin
            dlo_in   = {key_ff[VALUE_WIDTH-1], key_ff} - {vlo_ff[VALUE_WIDTH-1], vlo_ff};
            dhi_in   = {vhi_ff[VALUE_WIDTH-1], vhi_ff} - {key_ff[VALUE_WIDTH-1], key_ff};
            state_in = S_PICK;
         end
         S_PICK: begin
            res_in   = ($signed(dlo_ff) > $signed(dhi_ff)) ? hi_ff : lo_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      last_ff      <= last_in;
      first_ff     <= first_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      vlo_ff       <= vlo_in;
      vhi_ff       <= vhi_in;
      dlo_ff       <= dlo_in;
      dhi_ff       <= dhi_in;
      res_ff       <= res_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = rsp_index_ff;

endmodule

>>> rtl/nearest_entry_binary_search_unit.sv
// Top level: stream ports, entry count register, table memory and search sequencer.
// Holds a monotone table of signed Q16.16 values in a synchronous RAM with registered read
// data and returns, for each query word, the index of the entry nearest the key (ties go to
// the lower bracket; keys past either end return that end). A write word stores one entry
// and gives no result. A query word is worked one at a time over the entries set by the
// count (saturated to the table depth): the first and last entries are read to find the
// table's orientation, then each bisection step takes one RAM read and one compare, and
// last the distances to both bracket entries are formed and the nearer one is picked.
// Counts of zero or one answer index 0. A finished result waits in an output register, so
// the next word is taken while it is still pending. Write entry_count only while idle.
module nearest_entry_binary_search_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,   // entry_count
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // entry_index [9:0], sample_value [41:10], zero pad
   input  logic [0:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // nearest_index [9:0], zero pad
);

   import nebs_pkg::*;

   logic [COUNT_WIDTH-1:0] entry_count_ff, entry_count_in;
   mem_req_type            mem_req;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic [INDEX_WIDTH-1:0] rsp_index;
   opcode_type             req_opcode;

   always_comb begin
      entry_count_in = csr_we ? csr_wdata : entry_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   assign req_opcode = opcode_type'(req_tuser);

   nebs_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (VALUE_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   nebs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .entry_count (entry_count_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_opcode  (req_opcode),
      .req_index   (req_tdata[INDEX_WIDTH-1:0]),
      .req_value   (req_tdata[INDEX_WIDTH +: VALUE_WIDTH]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_index   (rsp_index),
      .mem_req     (mem_req),
      .rd_data     (rd_data)
   );

   assign rsp_tdata = {(16 - INDEX_WIDTH)'(0), rsp_index};

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_WRITE) && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("write word produced a result");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_QUERY)) |=> !req_tready)
      else $error("new word accepted during a query");

   a_write_stays_ready: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_WRITE)) |=> req_tready)
      else $error("write word stalled the input");

endmodule
